// ===== sv/mrsb_pkg.sv =====
// shared types and constants for the mono rotate/scale pixel blitter
`timescale 1ns / 1ps
package mrsb_pkg;

  typedef enum logic [2:0] {
    REG_ROTATION      = 3'd0,
    REG_OFFSET_X      = 3'd1,
    REG_OFFSET_Y      = 3'd2,
    REG_SCALED_WIDTH  = 3'd3,
    REG_SCALED_HEIGHT = 3'd4,
    REG_PIXEL_FORMAT  = 3'd5,
    REG_FILL_ENABLE   = 3'd6,
    REG_FILL_COLOR    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    FMT_32 = 2'd0,
    FMT_24 = 2'd1,
    FMT_16 = 2'd2,
    FMT_15 = 2'd3
  } pix_fmt_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  localparam logic [31:0] WHITE_24 = 32'h00FF_FFFF;
  localparam logic [31:0] WHITE_16 = 32'h0000_FFFF;
  localparam logic [31:0] WHITE_15 = 32'h0000_7FFF;
  localparam logic [31:0] MASK_24  = 32'h00FF_FFFF;
  localparam logic [4:0]  MASK_5   = 5'h1F;

  localparam int unsigned CW = 14; // sign bit index of signed positions, which are CW+1 bits wide
  localparam int unsigned DIVW = 24; // dividend width

  // classified request passed front to back
  typedef struct packed {
    logic                 wr;
    logic [14:0]          wr_addr;
    logic [7:0]           wr_data;
    logic                 in_img;
    logic [DIVW-1:0]      num_x;
    logic [DIVW-1:0]      num_y;
    logic [12:0]          den_x;
    logic [12:0]          den_y;
    logic [31:0]          bg;
    logic [31:0]          white;
    logic [1:0]           rot;
  } req_t;

  function automatic logic [31:0] conv_bg(input logic [1:0] fmt, input logic en,
                                          input logic [31:0] c);
    logic [31:0] r;
    r = '0;
    if (en) begin
      case (pix_fmt_e'(fmt))
        FMT_32: r = c;
        FMT_24: r = c & MASK_24;
        FMT_16: r = {16'd0, c[14:10] & MASK_5, 1'b0, c[9:5] & MASK_5, c[4:0] & MASK_5};
        FMT_15: r = {17'd0, c[14:10] & MASK_5, c[9:5] & MASK_5, c[4:0] & MASK_5};
        default: r = c;
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] white_of(input logic [1:0] fmt);
    logic [31:0] r;
    r = WHITE_24;
    case (pix_fmt_e'(fmt))
      FMT_16:  r = WHITE_16;
      FMT_15:  r = WHITE_15;
      default: r = WHITE_24;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/mrsb_front.sv =====
// front end: places the image, tests coverage and forms the divide operands
`timescale 1ns / 1ps
module mrsb_front #(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 768,
  parameter int unsigned FRAME_W  = 512,
  parameter int unsigned FRAME_H  = 342
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               command_i,
  input  logic [14:0]        source_address_i,
  input  logic [7:0]         source_byte_i,
  input  logic [9:0]         dest_x_i,
  input  logic [9:0]         dest_y_i,
  input  logic [1:0]         rotation_i,
  input  logic signed [12:0] offset_x_i,
  input  logic signed [12:0] offset_y_i,
  input  logic [11:0]        scaled_width_i,
  input  logic [11:0]        scaled_height_i,
  input  logic [1:0]         pixel_format_i,
  input  logic               fill_enable_i,
  input  logic [31:0]        fill_color_i,
  output logic               valid_o,
  input  logic               stall_i,
  output mrsb_pkg::req_t     req_o
);
  localparam int unsigned CW = mrsb_pkg::CW;
  localparam int unsigned DW = mrsb_pkg::DIVW;

  logic               fits, rot_odd, adv;
  logic signed [CW:0] x0, y0, xr, yr;
  logic [12:0]        span_w, span_h;
  logic [11:0]        rot_w, rot_h;
  mrsb_pkg::req_t     req_d, req_q;
  logic               vld_q;

  assign adv     = !vld_q || !stall_i;
  assign stall_o = !adv;

  always_comb begin
    rot_odd = rotation_i[0];
    rot_w   = rot_odd ? 12'(FRAME_H) : 12'(FRAME_W);
    rot_h   = rot_odd ? 12'(FRAME_W) : 12'(FRAME_H);
    fits    = ({1'b0, scaled_width_i} <= 13'(SCREEN_W)) &&
              ({1'b0, scaled_height_i} <= 13'(SCREEN_H));
    if (fits) begin
      span_w = {1'b0, scaled_width_i};
      span_h = {1'b0, scaled_height_i};
      x0 = (CW+1)'(signed'({1'b0, 13'((13'(SCREEN_W) - span_w) >> 1)})) +
           (CW+1)'(offset_x_i);
      y0 = (CW+1)'(signed'({1'b0, 13'((13'(SCREEN_H) - span_h) >> 1)})) +
           (CW+1)'(offset_y_i);
    end else begin
      span_w = 13'(SCREEN_W);
      span_h = 13'(SCREEN_H);
      x0 = (CW+1)'(offset_x_i);
      y0 = (CW+1)'(offset_y_i);
    end
    xr = (CW+1)'(signed'({1'b0, dest_x_i})) - x0;
    yr = (CW+1)'(signed'({1'b0, dest_y_i})) - y0;
    req_d.wr      = !command_i;
    req_d.wr_addr = source_address_i;
    req_d.wr_data = source_byte_i;
    req_d.in_img = ({3'b0, dest_x_i} < 13'(SCREEN_W)) &&
                   ({3'b0, dest_y_i} < 13'(SCREEN_H)) &&
                   (span_w != '0) && (span_h != '0) && !xr[CW] && !yr[CW] &&
                   (xr < (CW+1)'(signed'({2'b0, span_w}))) &&
                   (yr < (CW+1)'(signed'({2'b0, span_h})));
    req_d.num_x = DW'(xr[11:0]) * DW'(rot_w);
    req_d.num_y = DW'(yr[11:0]) * DW'(rot_h);
    req_d.den_x = span_w;
    req_d.den_y = span_h;
    req_d.bg    = mrsb_pkg::conv_bg(pixel_format_i, fill_enable_i, fill_color_i);
    req_d.white = mrsb_pkg::white_of(pixel_format_i);
    req_d.rot   = rotation_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = vld_q;
  assign req_o   = req_q;
endmodule

// ===== sv/mrsb_back.sv =====
// back end: pipelined restoring dividers, rotation, frame read and colour
`timescale 1ns / 1ps
module mrsb_back #(
  parameter int unsigned FRAME_W = 512,
  parameter int unsigned FRAME_H = 342
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  mrsb_pkg::req_t req_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [31:0]    pixel_value_o,
  output logic           covered_o
);
  localparam int unsigned DW     = mrsb_pkg::DIVW;
  localparam int unsigned STRIDE = (FRAME_W + 7) / 8;
  localparam int unsigned NBYTES = STRIDE * FRAME_H;
  localparam int unsigned AW     = $clog2(NBYTES);
  localparam int unsigned NS     = DW;          // one quotient bit per stage
  localparam int unsigned RW     = 14;          // partial remainder width

  // each stage carries remainder, dividend shift and quotient for x and y
  logic           v_q  [1:NS];
  mrsb_pkg::req_t r_q  [1:NS];
  logic [RW-1:0]  rx_q [1:NS];
  logic [RW-1:0]  ry_q [1:NS];
  logic [DW-1:0]  nx_q [1:NS];
  logic [DW-1:0]  ny_q [1:NS];

  logic          adv;
  logic          out_v_q, mem_v_q;
  logic          mem_cov_q, mem_bit_ok_q;
  logic [2:0]    mem_bit_q;
  logic [31:0]   mem_bg_q, mem_white_q;
  logic [7:0]    rd_q;
  logic [7:0]    mem [NBYTES];
  logic [31:0]   pv_q;
  logic          cov_q;

  // single global advance: the whole pipe freezes under output stall
  assign adv     = !out_v_q || !stall_i;
  assign stall_o = !adv;

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic           v_in;
    mrsb_pkg::req_t r_in;
    logic [RW-1:0]  rx_in, ry_in;
    logic [DW-1:0]  nx_in, ny_in;
    logic [RW:0]    tx, ty;
    logic [RW-1:0]  rx_d, ry_d;
    logic [DW-1:0]  nx_d, ny_d;
    if (s == 0) begin : g_head
      assign v_in  = valid_i;
      assign r_in  = req_i;
      assign rx_in = '0;
      assign ry_in = '0;
      assign nx_in = req_i.num_x;
      assign ny_in = req_i.num_y;
    end else begin : g_body
      assign v_in  = v_q[s];
      assign r_in  = r_q[s];
      assign rx_in = rx_q[s];
      assign ry_in = ry_q[s];
      assign nx_in = nx_q[s];
      assign ny_in = ny_q[s];
    end
    always_comb begin
      tx = {rx_in, nx_in[DW-1]};
      ty = {ry_in, ny_in[DW-1]};
      if (tx >= (RW+1)'(r_in.den_x)) begin
        rx_d = RW'(tx - (RW+1)'(r_in.den_x));
        nx_d = {nx_in[DW-2:0], 1'b1};
      end else begin
        rx_d = RW'(tx);
        nx_d = {nx_in[DW-2:0], 1'b0};
      end
      if (ty >= (RW+1)'(r_in.den_y)) begin
        ry_d = RW'(ty - (RW+1)'(r_in.den_y));
        ny_d = {ny_in[DW-2:0], 1'b1};
      end else begin
        ry_d = RW'(ty);
        ny_d = {ny_in[DW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (adv) begin
        v_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[s+1]  <= r_in;
        rx_q[s+1] <= rx_d;
        ry_q[s+1] <= ry_d;
        nx_q[s+1] <= nx_d;
        ny_q[s+1] <= ny_d;
      end
    end
  end

  // rotation back to source coordinates, quotients are below 2048
  logic [11:0]   qx, qy;
  logic signed [13:0] sx, sy;
  logic          in_src;
  logic [AW-1:0] rd_addr;
  logic [25:0]   lin;
  always_comb begin
    qx = nx_q[NS][11:0];
    qy = ny_q[NS][11:0];
    case (mrsb_pkg::rot_e'(r_q[NS].rot))
      mrsb_pkg::ROT_90: begin
        sx = 14'(qy);
        sy = 14'(FRAME_H - 1) - 14'(qx);
      end
      mrsb_pkg::ROT_180: begin
        sx = 14'(FRAME_W - 1) - 14'(qx);
        sy = 14'(FRAME_H - 1) - 14'(qy);
      end
      mrsb_pkg::ROT_270: begin
        sx = 14'(FRAME_W - 1) - 14'(qy);
        sy = 14'(qx);
      end
      default: begin
        sx = 14'(qx);
        sy = 14'(qy);
      end
    endcase
    in_src  = !sx[13] && !sy[13] && (sx < 14'(FRAME_W)) && (sy < 14'(FRAME_H));
    lin     = 26'(sy[12:0]) * 26'(STRIDE) + 26'(sx[12:3]);
    rd_addr = AW'(lin);
  end

  // writes land here in request order, so a pixel always sees earlier writes only
  always_ff @(posedge clk_i) begin
    if (adv && v_q[NS] && r_q[NS].wr &&
        ({17'd0, r_q[NS].wr_addr} < 32'(NBYTES))) begin
      mem[AW'(r_q[NS].wr_addr)] <= r_q[NS].wr_data;
    end
    if (adv) begin
      rd_q         <= mem[rd_addr];
      mem_cov_q    <= r_q[NS].in_img;
      mem_bit_ok_q <= in_src;
      mem_bit_q    <= sx[2:0];
      mem_bg_q     <= r_q[NS].bg;
      mem_white_q  <= r_q[NS].white;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      mem_v_q <= v_q[NS] && !r_q[NS].wr;
      out_v_q <= mem_v_q;
    end
  end

  logic blk;
  assign blk = mem_bit_ok_q && rd_q[3'd7 - mem_bit_q];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cov_q <= mem_cov_q;
      pv_q  <= !mem_cov_q ? mem_bg_q : (blk ? 32'd0 : mem_white_q);
    end
  end

  assign valid_o       = out_v_q;
  assign pixel_value_o = pv_q;
  assign covered_o     = cov_q;
endmodule

// ===== sv/mono_rotate_scale_pixel_blit.sv =====
// top level of the mono rotate/scale pixel blitter
`timescale 1ns / 1ps
// a pixel request passes 27 registers on its way to its result
// (1 front, 24 divider stages, 1 frame read, 1 colour and output)
// throughput: one request per cycle unless stalled, set by the fully pipelined dividers
// writes follow the same pipe, land in the frame at the read stage and give no result
// an output stall freezes the whole back end; the front register then fills and stalls
// reset clears registers to defaults and the pipe valid bits; the frame is not cleared
module mono_rotate_scale_pixel_blit #(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 768,
  parameter int unsigned FRAME_W  = 512,
  parameter int unsigned FRAME_H  = 342
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        command_i,
  input  logic [14:0] source_address_i,
  input  logic [7:0]  source_byte_i,
  input  logic [9:0]  dest_x_i,
  input  logic [9:0]  dest_y_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] pixel_value_o,
  output logic        covered_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  // configuration registers
  logic [1:0]         rotation_q;
  logic signed [12:0] offset_x_q, offset_y_q;
  logic [11:0]        scaled_width_q, scaled_height_q;
  logic [1:0]         pixel_format_q;
  logic               fill_enable_q;
  logic [31:0]        fill_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q      <= '0;
      offset_x_q      <= '0;
      offset_y_q      <= '0;
      scaled_width_q  <= 12'd512;
      scaled_height_q <= 12'd342;
      pixel_format_q  <= '0;
      fill_enable_q   <= 1'b0;
      fill_color_q    <= '0;
    end else if (cfg_we_i) begin
      case (mrsb_pkg::reg_idx_e'(cfg_idx_i))
        mrsb_pkg::REG_ROTATION:      rotation_q      <= cfg_data_i[1:0];
        mrsb_pkg::REG_OFFSET_X:      offset_x_q      <= cfg_data_i[12:0];
        mrsb_pkg::REG_OFFSET_Y:      offset_y_q      <= cfg_data_i[12:0];
        mrsb_pkg::REG_SCALED_WIDTH:  scaled_width_q  <= cfg_data_i[11:0];
        mrsb_pkg::REG_SCALED_HEIGHT: scaled_height_q <= cfg_data_i[11:0];
        mrsb_pkg::REG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data_i[1:0];
        mrsb_pkg::REG_FILL_ENABLE:   fill_enable_q   <= cfg_data_i[0];
        mrsb_pkg::REG_FILL_COLOR:    fill_color_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // every request enters the front end; writes ride along to keep their order
  logic           front_stall, back_stall, q_valid;
  mrsb_pkg::req_t q_req;

  assign stall_o = front_stall;

  mrsb_front #(
    .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H),
    .FRAME_W(FRAME_W), .FRAME_H(FRAME_H)
  ) u_front (
    .clk_i, .rst_ni,
    .valid_i,
    .stall_o         (front_stall),
    .command_i, .source_address_i, .source_byte_i,
    .dest_x_i, .dest_y_i,
    .rotation_i      (rotation_q),
    .offset_x_i      (offset_x_q),
    .offset_y_i      (offset_y_q),
    .scaled_width_i  (scaled_width_q),
    .scaled_height_i (scaled_height_q),
    .pixel_format_i  (pixel_format_q),
    .fill_enable_i   (fill_enable_q),
    .fill_color_i    (fill_color_q),
    .valid_o         (q_valid),
    .stall_i         (back_stall),
    .req_o           (q_req)
  );

  mrsb_back #(
    .FRAME_W(FRAME_W), .FRAME_H(FRAME_H)
  ) u_back (
    .clk_i, .rst_ni,
    .valid_i   (q_valid),
    .stall_o   (back_stall),
    .req_i     (q_req),
    .valid_o, .stall_i, .pixel_value_o, .covered_o
  );
endmodule
